### rtl/core/es2cal_pkg.sv
// ----------------------------------------------------------------------------
// es2cal_pkg
// Constants and helpers for the epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
package es2cal_pkg;

    localparam int unsigned SECS_PER_HOUR = 3600;

    // x / 60 for any 32-bit x: (x * M) >> 37
    localparam logic [31:0] DIV60_MAGIC = 32'h8888_8889;
    localparam int unsigned DIV60_SHIFT = 37;

    // x / 3 for x < 2^18: (x * M) >> 19 (used for hours / 24 after >> 3)
    localparam logic [17:0] DIV3_MAGIC  = 18'd174763;
    localparam int unsigned DIV3_SHIFT  = 19;

    // x / 7 for x < 2^16: (x * M) >> 19
    localparam logic [16:0] DIV7_MAGIC  = 17'd74899;
    localparam int unsigned DIV7_SHIFT  = 19;

    // x / 1461 for x < 2^18: (x * M) >> 29
    localparam logic [18:0] DIV1461_MAGIC = 19'd367469;
    localparam int unsigned DIV1461_SHIFT = 29;

    // x / 153 for x < 2^11: (x * M) >> 18
    localparam logic [10:0] DIV153_MAGIC = 11'd1714;
    localparam int unsigned DIV153_SHIFT = 18;

    // Julian day number of 1970-01-01, mod 7 (Monday is 0)
    localparam logic [15:0] WEEKDAY_BIAS = 16'd3;

    // Gregorian 400-year cycle index b is 67, 68 or 69 over 1970..2106.
    // Thresholds and c offsets are expressed against the day count.
    localparam logic [15:0] DAYS_B68 = 16'd11017;
    localparam logic [15:0] DAYS_B69 = 16'd47541;
    localparam logic [16:0] C_OFS_B67 = 17'd25508;
    localparam logic [16:0] C_OFS_B68 = 17'h1_D4F7;   // -11017
    localparam logic [16:0] C_OFS_B69 = 17'h1_464B;   // -47541

    typedef enum logic [1:0] {
        CENT_B67 = 2'd0,
        CENT_B68 = 2'd1,
        CENT_B69 = 2'd2
    } cent_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] min;
        logic [5:0] sec;
    } tod_t;

    // (153 * m + 2) / 5, days from March 1 to the start of shifted month m
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts a 32-bit seconds-since-1970 word, shifted by a whole-hour zone
// offset, into Gregorian date, time of day and weekday.
// ----------------------------------------------------------------------------
// Pipeline: nine register stages, the last being the output register; a result
// word is valid on m_ once it has passed through all of them.
// Throughput: one word per cycle; the whole pipe advances together and
// freezes while the output register holds a word that is not taken.
// Reset (aresetn low, synchronous): all valid bits clear, zone offset is 0.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
    input  logic              aclk,
    input  logic              aresetn,

    // zone offset write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic signed [4:0] cfg_tz_offset_hours,

    // input words
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [31:0]       s_epoch_seconds,

    // result words
    output logic              m_valid,
    input  logic              m_ready,
    output logic signed [7:0] m_year_since_2000,
    output logic [3:0]        m_month_number,
    output logic [4:0]        m_day_of_month,
    output logic [4:0]        m_hour_of_day,
    output logic [5:0]        m_minute_of_hour,
    output logic [5:0]        m_second_of_minute,
    output logic [2:0]        m_weekday
);

    // ------------------------------------------------------------------
    // Zone offset, kept pre-scaled to seconds so stage 1 is a single add.
    // ------------------------------------------------------------------
    logic [31:0] off_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg <= '0;
        end else if (cfg_valid) begin
            off_reg <= 32'($signed(cfg_tz_offset_hours) *
                           $signed(32'(es2cal_pkg::SECS_PER_HOUR)));
        end
    end

    // ------------------------------------------------------------------
    // Global advance: every stage moves when the output slot is free or
    // being drained. Bubbles simply travel along.
    // ------------------------------------------------------------------
    logic en;
    logic m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // valid bits for stages 1..8; stage 9 is the output register
    logic [8:1] v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v_reg       <= {v_reg[7:1], s_valid};
            m_valid_reg <= v_reg[8];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: apply zone offset, wraps modulo 2^32.
    // ------------------------------------------------------------------
    logic [31:0] ts1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ts1_reg <= s_epoch_seconds + off_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: total minutes = ts / 60 by reciprocal multiply.
    // ------------------------------------------------------------------
    logic [63:0] min_prod;
    logic [26:0] tmin2_next;
    logic [26:0] tmin2_reg;
    logic [5:0]  ts2_reg;

    assign min_prod   = 64'(ts1_reg) * 64'(es2cal_pkg::DIV60_MAGIC);
    assign tmin2_next = min_prod[es2cal_pkg::DIV60_SHIFT +: 27];

    always_ff @(posedge aclk) begin
        if (en) begin
            tmin2_reg <= tmin2_next;
            ts2_reg   <= ts1_reg[5:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: seconds from the low bits; total hours = minutes / 60.
    // ------------------------------------------------------------------
    logic [63:0] hr_prod;
    logic [20:0] thour3_next;
    logic [5:0]  sec3_next;
    logic [31:0] tmin_x60;
    logic [20:0] thour3_reg;
    logic [5:0]  tmin3_reg;
    logic [5:0]  sec3_reg;

    assign hr_prod     = 64'(tmin2_reg) * 64'(es2cal_pkg::DIV60_MAGIC);
    assign thour3_next = hr_prod[es2cal_pkg::DIV60_SHIFT +: 21];
    assign tmin_x60    = 32'(tmin2_reg) * 32'd60;
    // remainder < 60, so 6 bits of the difference are exact
    assign sec3_next   = ts2_reg - tmin_x60[5:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            thour3_reg <= thour3_next;
            tmin3_reg  <= tmin2_reg[5:0];
            sec3_reg   <= sec3_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: minutes of hour; days = hours / 24 = (hours >> 3) / 3.
    // ------------------------------------------------------------------
    logic [35:0] day_prod;
    logic [15:0] days4_next;
    logic [26:0] thour_x60;
    logic [5:0]  min4_next;
    logic [15:0] days4_reg;
    logic [4:0]  thour4_reg;
    logic [5:0]  min4_reg;
    logic [5:0]  sec4_reg;

    assign day_prod   = 36'(thour3_reg[20:3]) * 36'(es2cal_pkg::DIV3_MAGIC);
    assign days4_next = day_prod[es2cal_pkg::DIV3_SHIFT +: 16];
    assign thour_x60  = 27'(thour3_reg) * 27'd60;
    assign min4_next  = tmin3_reg - thour_x60[5:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            days4_reg  <= days4_next;
            thour4_reg <= thour3_reg[4:0];
            min4_reg   <= min4_next;
            sec4_reg   <= sec3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: hour of day; 400-year index b by compare against the day
    // count, c = a - floor(146097 * b / 4) as one offset add; start of the
    // weekday reduction (days + bias) / 7.
    // ------------------------------------------------------------------
    logic [20:0]          days_x24;
    logic [4:0]           hour5_next;
    es2cal_pkg::cent_t    cent5_next;
    logic [16:0]          c_ofs;
    logic [16:0]          c_wide;
    logic [15:0]          wd_x;
    logic [32:0]          wd_prod;
    logic [12:0]          wd_q5_next;
    es2cal_pkg::tod_t     tod5_reg;
    es2cal_pkg::cent_t    cent5_reg;
    logic [15:0]          c5_reg;
    logic [12:0]          wd_q5_reg;
    logic [2:0]           wd_x5_reg;

    assign days_x24   = 21'(days4_reg) * 21'd24;
    assign hour5_next = thour4_reg - days_x24[4:0];

    always_comb begin
        if (days4_reg >= es2cal_pkg::DAYS_B69) begin
            cent5_next = es2cal_pkg::CENT_B69;
            c_ofs      = es2cal_pkg::C_OFS_B69;
        end else if (days4_reg >= es2cal_pkg::DAYS_B68) begin
            cent5_next = es2cal_pkg::CENT_B68;
            c_ofs      = es2cal_pkg::C_OFS_B68;
        end else begin
            cent5_next = es2cal_pkg::CENT_B67;
            c_ofs      = es2cal_pkg::C_OFS_B67;
        end
    end

    assign c_wide     = {1'b0, days4_reg} + c_ofs;
    assign wd_x       = days4_reg + es2cal_pkg::WEEKDAY_BIAS;
    assign wd_prod    = 33'(wd_x) * 33'(es2cal_pkg::DIV7_MAGIC);
    assign wd_q5_next = wd_prod[es2cal_pkg::DIV7_SHIFT +: 13];

    always_ff @(posedge aclk) begin
        if (en) begin
            tod5_reg  <= '{hour: hour5_next, min: min4_reg, sec: sec4_reg};
            cent5_reg <= cent5_next;
            c5_reg    <= c_wide[15:0];
            wd_q5_reg <= wd_q5_next;
            wd_x5_reg <= wd_x[2:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: d = (4c + 3) / 1461 (year within the 4-year cycle),
    // weekday remainder.
    // ------------------------------------------------------------------
    logic [17:0]       d_x;
    logic [36:0]       d_prod;
    logic [6:0]        d6_next;
    logic [15:0]       wd_q_x7;
    logic [2:0]        wd6_next;
    es2cal_pkg::tod_t  tod6_reg;
    es2cal_pkg::cent_t cent6_reg;
    logic [15:0]       c6_reg;
    logic [6:0]        d6_reg;
    logic [2:0]        wd6_reg;

    assign d_x      = {c5_reg, 2'b11};
    assign d_prod   = 37'(d_x) * 37'(es2cal_pkg::DIV1461_MAGIC);
    assign d6_next  = d_prod[es2cal_pkg::DIV1461_SHIFT +: 7];
    assign wd_q_x7  = 16'(wd_q5_reg) * 16'd7;
    assign wd6_next = wd_x5_reg - wd_q_x7[2:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            tod6_reg  <= tod5_reg;
            cent6_reg <= cent5_reg;
            c6_reg    <= c5_reg;
            d6_reg    <= d6_next;
            wd6_reg   <= wd6_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: e = c - floor(1461 * d / 4), day within the March-based year.
    // ------------------------------------------------------------------
    logic [17:0]       d_x1461;
    logic [15:0]       e_wide;
    es2cal_pkg::tod_t  tod7_reg;
    es2cal_pkg::cent_t cent7_reg;
    logic [6:0]        d7_reg;
    logic [8:0]        e7_reg;
    logic [2:0]        wd7_reg;

    assign d_x1461 = 18'(d6_reg) * 18'd1461;
    assign e_wide  = c6_reg - d_x1461[17:2];

    always_ff @(posedge aclk) begin
        if (en) begin
            tod7_reg  <= tod6_reg;
            cent7_reg <= cent6_reg;
            d7_reg    <= d6_reg;
            e7_reg    <= e_wide[8:0];
            wd7_reg   <= wd6_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: shifted month m = (5e + 2) / 153, 0 is March.
    // ------------------------------------------------------------------
    logic [10:0]       m_x;
    logic [21:0]       m_prod;
    es2cal_pkg::tod_t  tod8_reg;
    es2cal_pkg::cent_t cent8_reg;
    logic [6:0]        d8_reg;
    logic [8:0]        e8_reg;
    logic [3:0]        m8_reg;
    logic [2:0]        wd8_reg;

    assign m_x    = 11'(e7_reg) * 11'd5 + 11'd2;
    assign m_prod = 22'(m_x) * 22'(es2cal_pkg::DIV153_MAGIC);

    always_ff @(posedge aclk) begin
        if (en) begin
            tod8_reg  <= tod7_reg;
            cent8_reg <= cent7_reg;
            d8_reg    <= d7_reg;
            e8_reg    <= e7_reg;
            m8_reg    <= m_prod[es2cal_pkg::DIV153_SHIFT +: 4];
            wd8_reg   <= wd7_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9 (output register): day of month, calendar month, year.
    // year - 2000 = 100 * (b - 68) + d + (m >= 10)
    // ------------------------------------------------------------------
    logic       jan_feb;
    logic [8:0] mday_wide;
    logic [3:0] month_next;
    logic [7:0] cent_ofs;
    logic [7:0] year_next;

    logic [7:0] year_reg;
    logic [3:0] month_reg;
    logic [4:0] mday_reg;
    logic [2:0] wd_reg;
    es2cal_pkg::tod_t tod_out_reg;

    assign jan_feb    = (m8_reg >= 4'd10);
    assign mday_wide  = e8_reg - es2cal_pkg::month_start(m8_reg) + 9'd1;
    assign month_next = jan_feb ? (m8_reg - 4'd9) : (m8_reg + 4'd3);

    always_comb begin
        case (cent8_reg)
            es2cal_pkg::CENT_B67: cent_ofs = 8'd156;   // -100
            es2cal_pkg::CENT_B69: cent_ofs = 8'd100;
            default:              cent_ofs = 8'd0;
        endcase
    end

    assign year_next = 8'(d8_reg) + 8'(jan_feb) + cent_ofs;

    always_ff @(posedge aclk) begin
        if (en) begin
            year_reg    <= year_next;
            month_reg   <= month_next;
            mday_reg    <= mday_wide[4:0];
            wd_reg      <= wd8_reg;
            tod_out_reg <= tod8_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_year_since_2000  = $signed(year_reg);
    assign m_month_number     = month_reg;
    assign m_day_of_month     = mday_reg;
    assign m_hour_of_day      = tod_out_reg.hour;
    assign m_minute_of_hour   = tod_out_reg.min;
    assign m_second_of_minute = tod_out_reg.sec;
    assign m_weekday          = wd_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (month_reg >= 4'd1 && month_reg <= 4'd12))
        else $error("month out of range");

    a_tod_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (tod_out_reg.hour < 5'd24 && tod_out_reg.min < 6'd60 &&
                         tod_out_reg.sec < 6'd60))
        else $error("time of day out of range");

    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (mday_reg >= 5'd1 && wd_reg < 3'd7))
        else $error("day of month or weekday out of range");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v_reg[1])
        else $error("accepted word did not enter stage 1");

    a_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(v_reg) && $stable(year_reg) && m_valid_reg))
        else $error("pipeline moved while stalled");

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for epoch_seconds_to_calendar: timestamp words are
// driven through valid/ready under random idle gaps and result stalls, and
// every result word is checked field by field against a local calendar
// predictor that runs with the zone offset currently programmed.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // Calendar arithmetic constants
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned HOURS_PER_DAY = 24;
    localparam int unsigned JDN_1970      = 2440588;  // Julian day of 1970-01-01
    localparam int unsigned JDN_SHIFT     = 32044;
    localparam int unsigned DAYS_400Y     = 146097;
    localparam int unsigned DAYS_4Y       = 1461;
    localparam int unsigned DAYS_5MON     = 153;
    localparam int unsigned YEAR_SHIFT    = 4800;
    localparam int unsigned YEAR_BASE     = 2000;
    localparam int unsigned LAST_DAY      = 49710;    // last day that starts within 32 bits

    localparam int RANDOM_WORDS = 950;
    localparam int MAX_PRINTS   = 50;
    localparam int DRAIN_CYCLES = 20;                 // idle wait after the final drain

    // One result word
    typedef struct packed {
        logic signed [7:0] yr;
        logic [3:0]        mon;
        logic [4:0]        mday;
        logic [4:0]        hr;
        logic [5:0]        mins;
        logic [5:0]        secs;
        logic [2:0]        wday;
    } cal_t;

    // Expected result with the timestamp that produced it, for messages
    typedef struct {
        logic [31:0] stamp;
        cal_t        want;
    } due_t;

    // Directed stimulus row; want is only used when typed is set
    typedef struct {
        logic signed [4:0] zone;
        logic [31:0]       stamp;
        bit                typed;
        cal_t              want;
    } dir_row_t;

    localparam cal_t NO_DATE = '0;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic              aclk;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic signed [4:0] cfg_tz_offset_hours;
    logic              s_valid;
    logic              s_ready;
    logic [31:0]       s_epoch_seconds;
    logic              m_valid;
    logic              m_ready;
    logic signed [7:0] m_year_since_2000;
    logic [3:0]        m_month_number;
    logic [4:0]        m_day_of_month;
    logic [4:0]        m_hour_of_day;
    logic [5:0]        m_minute_of_hour;
    logic [5:0]        m_second_of_minute;
    logic [2:0]        m_weekday;

    epoch_seconds_to_calendar DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_tz_offset_hours(cfg_tz_offset_hours),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_epoch_seconds    (s_epoch_seconds),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_year_since_2000  (m_year_since_2000),
        .m_month_number     (m_month_number),
        .m_day_of_month     (m_day_of_month),
        .m_hour_of_day      (m_hour_of_day),
        .m_minute_of_hour   (m_minute_of_hour),
        .m_second_of_minute (m_second_of_minute),
        .m_weekday          (m_weekday)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    due_t              due_dates[$];      // expected result words, oldest first
    logic signed [4:0] zone_hours;        // offset as the DUT should hold it
    int                mismatch_count;
    bit                calm;              // phase without idle gaps or stalls

    // Typed expectation riding along with the word on s_, held with the payload
    bit                s_typed;
    cal_t              s_typed_date;

    // ------------------------------------------------------------------------
    // Predictor: Julian day integer formulas, 32-bit unsigned like the block
    // ------------------------------------------------------------------------
    function automatic cal_t civil_date_of(input logic [31:0] stamp,
                                           input logic signed [4:0] zone);
        int          zone_secs;
        logic [31:0] t, jdn, a, b, c, d, e, m, yr;
        cal_t        r;
        zone_secs = zone;                 // sign-extends
        zone_secs = zone_secs * SECS_PER_HOUR;
        t = stamp + 32'(zone_secs);       // wraps mod 2^32
        r.secs = 6'(t % SECS_PER_MIN);
        r.mins = 6'((t / SECS_PER_MIN) % SECS_PER_MIN);
        r.hr   = 5'((t / SECS_PER_HOUR) % HOURS_PER_DAY);
        jdn    = t / SECS_PER_DAY + JDN_1970;
        r.wday = 3'(jdn % 7);
        a = jdn + JDN_SHIFT;
        b = (4 * a + 3) / DAYS_400Y;
        c = a - (DAYS_400Y * b) / 4;
        d = (4 * c + 3) / DAYS_4Y;
        e = c - (DAYS_4Y * d) / 4;
        m = (5 * e + 2) / DAYS_5MON;
        r.mday = 5'(e - (DAYS_5MON * m + 2) / 5 + 1);
        r.mon  = 4'(m + 3 - 12 * (m / 10));
        yr     = 100 * b + d + m / 10 - YEAR_SHIFT - YEAR_BASE;
        r.yr   = 8'(yr);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] stamp,
                               input int want, input int got);
        if (want != got) begin
            report_mismatch($sformatf("%s for stamp 0x%08h: expected %0d, got %0d",
                                      name, stamp, want, got));
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Monitor: everything sampled at the rising edge, before the DUT's
    // registers update. Config writes only land while the pipe is empty,
    // so the offset used here is the one the DUT applied.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        due_t head;
        cal_t got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                zone_hours = cfg_tz_offset_hours;
            end
            if (s_valid && s_ready) begin
                due_dates.push_back('{s_epoch_seconds,
                                      s_typed ? s_typed_date
                                              : civil_date_of(s_epoch_seconds, zone_hours)});
            end
            if (m_valid && m_ready) begin
                got = '{m_year_since_2000, m_month_number, m_day_of_month,
                        m_hour_of_day, m_minute_of_hour, m_second_of_minute, m_weekday};
                if (due_dates.size() == 0) begin
                    report_mismatch($sformatf("result word with nothing expected (%p)", got));
                end else begin
                    head = due_dates.pop_front();
                    check_field("year",    head.stamp, int'(head.want.yr), int'(got.yr));
                    check_field("month",   head.stamp, head.want.mon,  got.mon);
                    check_field("day",     head.stamp, head.want.mday, got.mday);
                    check_field("hour",    head.stamp, head.want.hr,   got.hr);
                    check_field("minute",  head.stamp, head.want.mins, got.mins);
                    check_field("second",  head.stamp, head.want.secs, got.secs);
                    check_field("weekday", head.stamp, head.want.wday, got.wday);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side: m_ready toggles at the falling edge, mostly high with
    // short stalls and the odd long one; no stalls in calm phases.
    // ------------------------------------------------------------------------
    initial begin
        int hold;
        int r;
        hold    = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_ready = 1'b0;
                hold--;
            end else begin
                m_ready = 1'b1;
                r = $urandom_range(0, 99);
                if (!calm && r < 12) begin
                    hold = $urandom_range(1, 3);
                end else if (!calm && r < 14) begin
                    hold = $urandom_range(10, 40);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side helpers. All of them start and end just after a falling edge.
    // ------------------------------------------------------------------------
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // One timestamp word; valid stays up afterwards so back-to-back words
    // go without a bubble.
    task automatic send_stamp(input logic [31:0] stamp, input bit typed,
                              input cal_t want);
        int gap;
        gap = idle_gap();
        repeat (gap) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_epoch_seconds = stamp;
        s_typed         = typed;
        s_typed_date    = want;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        @(negedge aclk);
    endtask

    // Stop sending and wait for every expected word to come back
    task automatic drain();
        s_valid = 1'b0;
        while (due_dates.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Zone offset write; caller guarantees the pipe is empty
    task automatic write_zone(input logic signed [4:0] zone);
        cfg_valid           = 1'b1;
        cfg_tz_offset_hours = zone;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Random timestamp: half uniform, plus day boundaries and the two
    // ends of the 32-bit range where offset wrap shows up.
    function automatic logic [31:0] pick_stamp();
        int unsigned day;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return $urandom;
        end else if (r < 80) begin
            day = $urandom_range(0, LAST_DAY);
            return day * SECS_PER_DAY + $urandom_range(0, 6) - 3;
        end else if (r < 90) begin
            return $urandom_range(0, 100000);
        end
        return 32'hFFFF_FFFF - $urandom_range(0, 100000);
    endfunction

    function automatic logic signed [4:0] pick_zone();
        case ($urandom_range(0, 5))
            0:       return -5'sd12;
            1:       return 5'sd14;
            2:       return 5'sd15;     // outside intended range
            3:       return -5'sd16;    // outside intended range
            default: return 5'($urandom_range(0, 31));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Directed table: epoch, Y2K, leap day, 2038, 2100 non-leap century,
    // the 32-bit end, offset wrap in both directions, offsets outside the
    // intended range. Rows with a typed date are checked against that date.
    // ------------------------------------------------------------------------
    dir_row_t directed[] = '{
        '{ 5'sd0,  32'd0,          1'b1, '{-8'sd30, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  3'd3}},
        '{ 5'sd0,  32'd86399,      1'b1, '{-8'sd30, 4'd1,  5'd1,  5'd23, 6'd59, 6'd59, 3'd3}},
        '{ 5'sd0,  32'd86400,      1'b1, '{-8'sd30, 4'd1,  5'd2,  5'd0,  6'd0,  6'd0,  3'd4}},
        '{ 5'sd0,  32'h7FFF_FFFF,  1'b1, '{ 8'sd38, 4'd1,  5'd19, 5'd3,  6'd14, 6'd7,  3'd1}},
        '{ 5'sd0,  32'h8000_0000,  1'b0, NO_DATE},
        '{ 5'sd0,  32'd946684799,  1'b1, '{-8'sd1,  4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 3'd4}},
        '{ 5'sd0,  32'd946684800,  1'b1, '{ 8'sd0,  4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  3'd5}},
        '{ 5'sd0,  32'd951782400,  1'b1, '{ 8'sd0,  4'd2,  5'd29, 5'd0,  6'd0,  6'd0,  3'd1}},
        '{ 5'sd0,  32'd951868800,  1'b0, NO_DATE},
        '{ 5'sd0,  32'h5555_5555,  1'b0, NO_DATE},
        '{ 5'sd0,  32'hAAAA_AAAA,  1'b0, NO_DATE},
        '{ 5'sd0,  32'd4107542399, 1'b0, NO_DATE},
        '{ 5'sd0,  32'd4107542400, 1'b0, NO_DATE},
        '{ 5'sd0,  32'hFFFF_FFFF,  1'b1, '{ 8'sd106, 4'd2, 5'd7,  5'd6,  6'd28, 6'd15, 3'd6}},
        '{-5'sd1,  32'd0,          1'b1, '{ 8'sd106, 4'd2, 5'd7,  5'd5,  6'd28, 6'd16, 3'd6}},
        '{-5'sd1,  32'd3599,       1'b1, '{ 8'sd106, 4'd2, 5'd7,  5'd6,  6'd28, 6'd15, 3'd6}},
        '{-5'sd1,  32'd3600,       1'b1, '{-8'sd30, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  3'd3}},
        '{-5'sd12, 32'd0,          1'b0, NO_DATE},
        '{-5'sd12, 32'hFFFF_FFFF,  1'b0, NO_DATE},
        '{ 5'sd14, 32'd0,          1'b1, '{-8'sd30, 4'd1,  5'd1,  5'd14, 6'd0,  6'd0,  3'd3}},
        '{ 5'sd14, 32'hFFFF_FFFF,  1'b1, '{-8'sd30, 4'd1,  5'd1,  5'd13, 6'd59, 6'd59, 3'd3}},
        '{ 5'sd15, 32'd0,          1'b1, '{-8'sd30, 4'd1,  5'd1,  5'd15, 6'd0,  6'd0,  3'd3}},
        '{-5'sd16, 32'd0,          1'b0, NO_DATE},
        '{-5'sd16, 32'h7FFF_FFFF,  1'b0, NO_DATE},
        '{ 5'sd5,  32'd951782400,  1'b0, NO_DATE}
    };

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic signed [4:0] drv_zone;
        int                sent;
        int                burst;
        aresetn             = 1'b0;
        cfg_valid           = 1'b0;
        cfg_tz_offset_hours = '0;
        s_valid             = 1'b0;
        s_epoch_seconds     = '0;
        s_typed             = 1'b0;
        s_typed_date        = NO_DATE;
        zone_hours          = '0;
        mismatch_count      = 0;
        calm                = 1'b0;
        drv_zone            = '0;     // reset value of the offset

        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // Directed part; the offset only changes with the pipe empty
        foreach (directed[i]) begin
            if (directed[i].zone != drv_zone) begin
                drain();
                drv_zone = directed[i].zone;
                write_zone(drv_zone);
            end
            send_stamp(directed[i].stamp, directed[i].typed, directed[i].want);
        end

        // Random part in phases, each with its own offset and idle pattern
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            drain();
            drv_zone = pick_zone();
            write_zone(drv_zone);
            calm  = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(60, 160);
            if (burst > RANDOM_WORDS - sent) begin
                burst = RANDOM_WORDS - sent;
            end
            repeat (burst) begin
                send_stamp(pick_stamp(), 1'b0, NO_DATE);
                sent++;
            end
        end

        // Wind down: everything back, then wait DRAIN_CYCLES to catch strays
        drain();
        calm = 1'b0;
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatch_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Run limit, well above the slowest correct run
    // ------------------------------------------------------------------------
    initial begin
        #5_000_000;
        $display("[%0t] run limit reached, %0d words outstanding",
                 $realtime, due_dates.size());
        $display("testbench: FAIL");
        $finish;
    end

endmodule
